// ----- rtl/cc20_pkg.sv -----
// Shared types and constants for the ChaCha20 keystream XOR block.
// No dependencies; used by every module under rtl/.
package cc20_pkg;

  // Item and result payloads.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_t;

  // Classified item as it travels from front to back.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [5:0]  pos;        // byte position in the keystream block
    logic [31:0] counter;    // block counter, meaningful when pos is zero
  } q_entry_t;

  // Configuration register file.
  typedef struct packed {
    logic [63:0] key_words_a;
    logic [63:0] key_words_b;
    logic [63:0] key_words_c;
    logic [63:0] key_words_d;
    logic [63:0] nonce_low_words;
    logic [31:0] nonce_top_word;
    logic [31:0] initial_counter;
  } cfg_t;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_A     = 3'd0,
    CFG_KEY_B     = 3'd1,
    CFG_KEY_C     = 3'd2,
    CFG_KEY_D     = 3'd3,
    CFG_NONCE_LOW = 3'd4,
    CFG_NONCE_TOP = 3'd5,
    CFG_INIT_CTR  = 3'd6
  } cfg_idx_t;

  localparam logic [63:0] KEY_A_RST = 64'h0506070801020304;
  localparam logic [63:0] KEY_B_RST = 64'h0d0e0f10090a0b0c;
  localparam logic [63:0] KEY_C_RST = 64'h1516171811121314;
  localparam logic [63:0] KEY_D_RST = 64'h1d1e1f20191a1b1c;
  localparam logic [31:0] INIT_CTR_RST = 32'h00000001;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  // Front-to-back queue.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

endpackage

// ----- rtl/cc20_fifo.sv -----
// Two-entry queue between the byte classifier and the keystream engine.
// Depends on cc20_pkg for the entry type and depth.
module cc20_fifo
  import cc20_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  q_entry_t           push_data,
  input  logic               pop,
  output q_entry_t           head,
  output logic               head_valid,
  output logic               full,
  output logic [Q_CNT_W-1:0] count
);

  q_entry_t           mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  assign head       = mem_r[rd_ptr_r];
  assign head_valid = (count_r != '0);
  assign full       = (count_r == Q_CNT_W'(Q_DEPTH));
  assign count      = count_r;

endmodule

// ----- rtl/cc20_front.sv -----
// Byte classifier: tracks message state, byte position and block counter.
// Depends on cc20_pkg; feeds cc20_fifo.
module cc20_front
  import cc20_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  input  logic [31:0] initial_counter,
  input  logic        q_full,
  output logic        push,
  output q_entry_t    push_data
);

  logic        message_open_r, message_open_nxt;
  logic [5:0]  byte_pos_r, byte_pos_nxt;
  logic [31:0] block_ctr_r, block_ctr_nxt;
  logic [5:0]  pos;
  logic [31:0] ctr_base;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    // a closed message restarts position and counter
    pos      = message_open_r ? byte_pos_r : 6'd0;
    ctr_base = message_open_r ? block_ctr_r : initial_counter;

    push_data.data_byte = in_data.data_byte;
    push_data.last_byte = in_data.last_byte;
    push_data.pos       = pos;
    push_data.counter   = ctr_base;

    block_ctr_nxt = (pos == 6'd0) ? ctr_base + 32'd1 : ctr_base;
    if (in_data.last_byte) begin
      message_open_nxt = 1'b0;
      byte_pos_nxt     = 6'd0;
    end else begin
      message_open_nxt = 1'b1;
      byte_pos_nxt     = pos + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      message_open_r <= 1'b0;
      byte_pos_r     <= 6'd0;
      block_ctr_r    <= 32'd1;
    end else if (push) begin
      message_open_r <= message_open_nxt;
      byte_pos_r     <= byte_pos_nxt;
      block_ctr_r    <= block_ctr_nxt;
    end
  end

endmodule

// ----- rtl/cc20_back.sv -----
// Keystream engine: one quarter-round step per cycle on four lanes, then
// feed-forward, then byte XOR into the output register. Depends on cc20_pkg.
module cc20_back
  import cc20_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  q_entry_t head,
  input  logic     head_valid,
  output logic     pop,
  output logic     busy,
  output logic     out_valid,
  input  logic     out_ready,
  output out_t     out_data
);

  localparam int RND_W = $clog2(DOUBLE_ROUNDS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FEED
  } state_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } qr_t;

  state_t           state_r;
  logic [2:0]       step_r;      // [2]: diagonal round, [1:0]: quarter-round step
  logic [RND_W-1:0] rnd_r;
  logic             blk_done_r;
  logic             out_valid_r;
  out_t             out_data_r;
  logic [31:0]      work_r   [16];
  logic [31:0]      work_nxt [16];
  logic [31:0]      init_w   [16];
  logic             need_block;
  logic             can_load;
  logic             last_step;
  logic [31:0]      ks_word;
  logic [7:0]       ks_byte;

  function automatic qr_t qr_step(input logic [1:0] sub, input qr_t v);
    qr_t r;
    logic [31:0] t;
    r = v;
    unique case (sub)
      2'd0: begin
        r.a = v.a + v.b;
        t   = v.d ^ r.a;
        r.d = {t[15:0], t[31:16]};
      end
      2'd1: begin
        r.c = v.c + v.d;
        t   = v.b ^ r.c;
        r.b = {t[19:0], t[31:20]};
      end
      2'd2: begin
        r.a = v.a + v.b;
        t   = v.d ^ r.a;
        r.d = {t[23:0], t[31:24]};
      end
      default: begin
        r.c = v.c + v.d;
        t   = v.b ^ r.c;
        r.b = {t[24:0], t[31:25]};
      end
    endcase
    return r;
  endfunction

  always_comb begin
    init_w[0]  = SIGMA0;
    init_w[1]  = SIGMA1;
    init_w[2]  = SIGMA2;
    init_w[3]  = SIGMA3;
    init_w[4]  = cfg.key_words_a[31:0];
    init_w[5]  = cfg.key_words_a[63:32];
    init_w[6]  = cfg.key_words_b[31:0];
    init_w[7]  = cfg.key_words_b[63:32];
    init_w[8]  = cfg.key_words_c[31:0];
    init_w[9]  = cfg.key_words_c[63:32];
    init_w[10] = cfg.key_words_d[31:0];
    init_w[11] = cfg.key_words_d[63:32];
    init_w[12] = head.counter;
    init_w[13] = cfg.nonce_low_words[31:0];
    init_w[14] = cfg.nonce_low_words[63:32];
    init_w[15] = cfg.nonce_top_word;
  end

  // Four independent quarter-round lanes; column or diagonal by step_r[2].
  always_comb begin
    logic [1:0] dg;
    logic [1:0] lane;
    logic [3:0] ib, ic, id;
    qr_t        v, r;
    dg = {1'b0, step_r[2]};
    for (int k = 0; k < 16; k++) work_nxt[k] = work_r[k];
    for (int i = 0; i < 4; i++) begin
      lane = 2'(i);
      ib   = {2'b01, 2'(lane + dg)};
      ic   = {2'b10, 2'(lane + {dg[0], 1'b0})};
      id   = {2'b11, 2'(lane + dg + {dg[0], 1'b0})};
      v.a  = work_r[{2'b00, lane}];
      v.b  = work_r[ib];
      v.c  = work_r[ic];
      v.d  = work_r[id];
      r    = qr_step(step_r[1:0], v);
      work_nxt[{2'b00, lane}] = r.a;
      work_nxt[ib] = r.b;
      work_nxt[ic] = r.c;
      work_nxt[id] = r.d;
    end
  end

  assign need_block = (head.pos == 6'd0) && !blk_done_r;
  assign can_load   = !out_valid_r || out_ready;
  assign pop        = (state_r == ST_IDLE) && head_valid && !need_block && can_load;
  assign last_step  = (step_r == 3'd7) && (rnd_r == RND_W'(DOUBLE_ROUNDS - 1));
  assign ks_word    = work_r[head.pos[5:2]];
  assign ks_byte    = ks_word[{head.pos[1:0], 3'b000} +: 8];

  // keystream store: holds the working state, then the finished block
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (head_valid && need_block) begin
          for (int k = 0; k < 16; k++) work_r[k] <= init_w[k];
        end
      end
      ST_ROUND: begin
        for (int k = 0; k < 16; k++) work_r[k] <= work_nxt[k];
      end
      default: begin
        for (int k = 0; k < 16; k++) work_r[k] <= work_r[k] + init_w[k];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= 3'd0;
      rnd_r       <= '0;
      blk_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (pop) begin
            out_valid_r         <= 1'b1;
            out_data_r.out_byte <= head.data_byte ^ ks_byte;
            out_data_r.out_last <= head.last_byte;
            blk_done_r          <= 1'b0;
          end else if (head_valid && need_block) begin
            step_r  <= 3'd0;
            rnd_r   <= '0;
            state_r <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          step_r <= step_r + 3'd1;
          if (step_r == 3'd7) rnd_r <= rnd_r + 1'b1;
          if (last_step) state_r <= ST_FEED;
        end
        default: begin
          blk_done_r <= 1'b1;
          state_r    <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/chacha20_keystream_xor.sv -----
// ChaCha20 keystream XOR, one message byte per transfer in and out.
// Each byte passes the queue and the output register; a byte that opens a
// keystream block first waits for the quarter-round steps and feed-forward.
// Throughput: one byte per cycle inside a block while the receiver is ready;
// the input stalls once the queue fills while a new block is generated.
// Reset: synchronous active-low rst_n; clears control, loads default key/nonce/counter.
module chacha20_keystream_xor
  import cc20_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input byte channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  // result byte channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  cfg_t               cfg_r;
  logic               q_full;
  logic               q_push;
  q_entry_t           q_push_data;
  logic               q_pop;
  q_entry_t           q_head;
  logic               q_head_valid;
  logic [Q_CNT_W-1:0] q_count;
  logic               bk_busy;

  // Register file: always ready, a write lands at its transfer edge. Writes
  // are expected only while no byte is in flight, so a block being generated
  // never sees key/nonce values change under it.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_words_a     <= KEY_A_RST;
      cfg_r.key_words_b     <= KEY_B_RST;
      cfg_r.key_words_c     <= KEY_C_RST;
      cfg_r.key_words_d     <= KEY_D_RST;
      cfg_r.nonce_low_words <= 64'd0;
      cfg_r.nonce_top_word  <= 32'd0;
      cfg_r.initial_counter <= INIT_CTR_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_KEY_A:     cfg_r.key_words_a     <= cfg_data;
        CFG_KEY_B:     cfg_r.key_words_b     <= cfg_data;
        CFG_KEY_C:     cfg_r.key_words_c     <= cfg_data;
        CFG_KEY_D:     cfg_r.key_words_d     <= cfg_data;
        CFG_NONCE_LOW: cfg_r.nonce_low_words <= cfg_data;
        CFG_NONCE_TOP: cfg_r.nonce_top_word  <= cfg_data[31:0];
        CFG_INIT_CTR:  cfg_r.initial_counter <= cfg_data[31:0];
        default: ;     // unused index, write dropped
      endcase
    end
  end

  // Front: message/position/counter bookkeeping, one byte per cycle while the queue is not full.
  cc20_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .initial_counter (cfg_r.initial_counter),
    .q_full          (q_full),
    .push            (q_push),
    .push_data       (q_push_data)
  );

  // Short queue decouples input transfers from block generation stalls.
  cc20_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_head_valid),
    .full       (q_full),
    .count      (q_count)
  );

  // Back: block generation on demand, XOR, output register.
  cc20_back #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (q_head),
    .head_valid (q_head_valid),
    .pop        (q_pop),
    .busy       (bk_busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

`ifndef SYNTHESIS
  // Block generation always runs for a queued byte.
  a_busy_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    bk_busy |-> (q_count != '0))
    else $error("keystream engine busy with empty queue");

  // No result appears while a block is being generated.
  a_no_out_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (bk_busy && !out_valid) |=> !out_valid)
    else $error("output loaded during block generation");

  // Queue full must back-pressure the input.
  a_full_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    (q_count == Q_CNT_W'(Q_DEPTH)) |-> !in_ready)
    else $error("input ready with queue full");

  // Reset leaves no result pending and the engine idle.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !bk_busy))
    else $error("reset did not clear output or engine");
`endif

endmodule

// ----- test/tb_chacha20_keystream_xor.sv -----
// Self-checking testbench for chacha20_keystream_xor: directed and random byte
// streams against an in-bench ChaCha20 keystream predictor.
// Depends on rtl/cc20_pkg.sv and rtl/chacha20_keystream_xor.sv.
module tb_chacha20_keystream_xor;
  import cc20_pkg::*;

  localparam int ROUNDS_DBL  = 10;
  localparam int QUIET_LIMIT = 5000;   // cycles with no transfer on any channel
  localparam int PHASE_BYTES = 145;    // random bytes per phase, roughly
  localparam int NUM_PHASES  = 8;
  localparam int LONG_HOLD   = 400;    // receiver back-pressure stretch
  localparam int DRAIN_WAIT  = 100;    // covers the worst block generation latency

  typedef logic [31:0] word_blk_t [16];

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_KEY_A;
  logic [63:0]          cfg_data  = '0;

  // Bytes waiting for the driver, and results waiting for the monitor.
  in_t  tx_bytes[$];
  out_t expected_bytes[$];
  int   bytes_unsent = 0;       // queued but not yet transferred into the block
  int   mismatches = 0;

  // Idle / stall knobs, percent out of 100, set per phase.
  int   sender_idle_pct = 0;
  int   receiver_stall_pct = 0;
  int   hold_request = 0;       // non-zero asks the receiver for a long hold-off
  int   hold_left = 0;
  int   quiet_cycles = 0;

  // Predictor state: shadow copy of the registers plus the keystream context.
  cfg_t        shadow_cfg = '{KEY_A_RST, KEY_B_RST, KEY_C_RST, KEY_D_RST,
                              64'd0, 32'd0, INIT_CTR_RST};
  word_blk_t   ks_block;
  logic [5:0]  ks_pos  = '0;
  logic [31:0] ks_ctr  = INIT_CTR_RST;
  logic        ks_open = 1'b0;

  chacha20_keystream_xor #(
    .DOUBLE_ROUNDS(ROUNDS_DBL)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // ChaCha20 predictor
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // One quarter-round; returns {a, b, c, d}.
  function automatic logic [127:0] qround(input logic [31:0] a, b, c, d);
    a = a + b; d = rotl(d ^ a, 16);
    c = c + d; b = rotl(b ^ c, 12);
    a = a + b; d = rotl(d ^ a, 8);
    c = c + d; b = rotl(b ^ c, 7);
    return {a, b, c, d};
  endfunction

  // Full keystream block for a given counter, using the current register shadow.
  function automatic word_blk_t chacha_block(input logic [31:0] ctr);
    word_blk_t init;
    word_blk_t x;
    init[0]  = SIGMA0;
    init[1]  = SIGMA1;
    init[2]  = SIGMA2;
    init[3]  = SIGMA3;
    init[4]  = shadow_cfg.key_words_a[31:0];
    init[5]  = shadow_cfg.key_words_a[63:32];
    init[6]  = shadow_cfg.key_words_b[31:0];
    init[7]  = shadow_cfg.key_words_b[63:32];
    init[8]  = shadow_cfg.key_words_c[31:0];
    init[9]  = shadow_cfg.key_words_c[63:32];
    init[10] = shadow_cfg.key_words_d[31:0];
    init[11] = shadow_cfg.key_words_d[63:32];
    init[12] = ctr;
    init[13] = shadow_cfg.nonce_low_words[31:0];
    init[14] = shadow_cfg.nonce_low_words[63:32];
    init[15] = shadow_cfg.nonce_top_word;
    x = init;
    for (int r = 0; r < ROUNDS_DBL; r++) begin
      // column round
      {x[0], x[4], x[8],  x[12]} = qround(x[0], x[4], x[8],  x[12]);
      {x[1], x[5], x[9],  x[13]} = qround(x[1], x[5], x[9],  x[13]);
      {x[2], x[6], x[10], x[14]} = qround(x[2], x[6], x[10], x[14]);
      {x[3], x[7], x[11], x[15]} = qround(x[3], x[7], x[11], x[15]);
      // diagonal round
      {x[0], x[5], x[10], x[15]} = qround(x[0], x[5], x[10], x[15]);
      {x[1], x[6], x[11], x[12]} = qround(x[1], x[6], x[11], x[12]);
      {x[2], x[7], x[8],  x[13]} = qround(x[2], x[7], x[8],  x[13]);
      {x[3], x[4], x[9],  x[14]} = qround(x[3], x[4], x[9],  x[14]);
    end
    for (int k = 0; k < 16; k++) x[k] = x[k] + init[k];
    return x;
  endfunction

  // Expected result for one accepted byte; advances the keystream context.
  function automatic out_t chacha_xor_byte(input in_t b);
    out_t       r;
    logic [7:0] ks;
    if (!ks_open) begin
      // message start: counter reloads, position restarts
      ks_ctr = shadow_cfg.initial_counter;
      ks_pos = '0;
    end
    if (ks_pos == 6'd0) begin
      ks_block = chacha_block(ks_ctr);
      ks_ctr   = ks_ctr + 32'd1;        // wraps at 32 bits
    end
    ks = ks_block[ks_pos[5:2]][ks_pos[1:0] * 8 +: 8];
    r.out_byte = b.data_byte ^ ks;
    r.out_last = b.last_byte;
    if (b.last_byte) begin
      ks_open = 1'b0;
      ks_pos  = '0;
    end else begin
      ks_open = 1'b1;
      ks_pos  = ks_pos + 6'd1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: one byte per transfer, random gaps per sender_idle_pct.
  // Valid only changes when the slot is free, so a held byte never moves.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        // predict at the transfer edge, registers are stable here
        expected_bytes.push_back(chacha_xor_byte(in_data));
        bytes_unsent--;
      end
      if (!in_valid || in_ready) begin
        if (tx_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= tx_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver ready: random stalls, plus a long hold-off on request so the
  // block fills up and has to push back on its input.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every result transfer is checked against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result: expected none, actual byte %h last %b",
                 $time, out_data.out_byte, out_data.out_last);
      end else begin
        exp_r = expected_bytes.pop_front();
        if (out_data.out_byte !== exp_r.out_byte || out_data.out_last !== exp_r.out_last) begin
          mismatches++;
          $display("%0t result mismatch: expected byte %h last %b, actual byte %h last %b",
                   $time, exp_r.out_byte, exp_r.out_last,
                   out_data.out_byte, out_data.out_last);
        end
      end
    end
  end

  // Watchdog: too long without any transfer means the block hung.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t watchdog: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] d, input logic l);
    in_t b;
    b.data_byte = d;
    b.last_byte = l;
    bytes_unsent++;
    tx_bytes.push_back(b);
  endtask

  // Random-content message; close=0 leaves it open across a register update.
  task automatic queue_message(input int len, input bit close);
    for (int i = 0; i < len; i++)
      queue_byte(8'($urandom_range(255)), close && (i == len - 1));
  endtask

  // Mostly short messages, some right on block boundaries, a few long.
  function automatic int pick_len();
    int sel;
    sel = $urandom_range(99);
    if (sel < 15) begin
      case ($urandom_range(3))
        0:       return 63;
        1:       return 64;
        2:       return 65;
        default: return 128;
      endcase
    end
    if (sel < 30) return $urandom_range(200, 1);
    return $urandom_range(70, 1);
  endfunction

  // Block is idle once every queued byte went in and every result came out.
  task automatic wait_drained();
    do @(posedge clk); while (bytes_unsent != 0 || expected_bytes.size() != 0);
  endtask

  // Single register write; the shadow follows at the transfer edge.
  task automatic cfg_write(input cfg_idx_t idx, input logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_KEY_A:     shadow_cfg.key_words_a     = val;
      CFG_KEY_B:     shadow_cfg.key_words_b     = val;
      CFG_KEY_C:     shadow_cfg.key_words_c     = val;
      CFG_KEY_D:     shadow_cfg.key_words_d     = val;
      CFG_NONCE_LOW: shadow_cfg.nonce_low_words = val;
      CFG_NONCE_TOP: shadow_cfg.nonce_top_word  = val[31:0];
      CFG_INIT_CTR:  shadow_cfg.initial_counter = val[31:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [63:0] ka, kb, kc, kd, nlo, ntop, ictr);
    cfg_write(CFG_KEY_A, ka);
    cfg_write(CFG_KEY_B, kb);
    cfg_write(CFG_KEY_C, kc);
    cfg_write(CFG_KEY_D, kd);
    cfg_write(CFG_NONCE_LOW, nlo);
    cfg_write(CFG_NONCE_TOP, ntop);
    cfg_write(CFG_INIT_CTR, ictr);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int          n;
    int          len;
    logic [63:0] ctr_val;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset key, single-byte messages, data extremes.
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hff, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hff, 1'b0);
    queue_byte(8'h5a, 1'b0);
    queue_byte(8'ha5, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h80, 1'b0);
    wait_drained();
    // Register update mid-message: the current keystream block must be kept.
    cfg_write(CFG_KEY_A, '1);
    cfg_write(CFG_NONCE_TOP, 64'hffff_ffff_ffff_ffff);
    for (int i = 0; i < 10; i++) queue_byte(8'hff - i[7:0], i == 9);
    // New message picks up the updated registers.
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hff, 1'b1);
    wait_drained();

    // Random phases, each with its own register setting and idle pattern.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: program_regs('0, '0, '0, '0, '0, '0, '0);
        1: program_regs('1, '1, '1, '1, '1, '1, '1);   // counter wraps past all-ones
        2: program_regs(KEY_A_RST, KEY_B_RST, KEY_C_RST, KEY_D_RST, '0, '0,
                        {32'd0, INIT_CTR_RST});
        default: begin
          ctr_val = (p == 5) ? {$urandom, 32'hffff_fffe} : {$urandom, $urandom};
          program_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                       {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                       ctr_val);
        end
      endcase
      case (p % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 60; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 60; end
        default: begin sender_idle_pct = 24; receiver_stall_pct = 24; end
      endcase
      // sender keeps offering while the receiver sits out a long stretch
      if (p == 4) hold_request = LONG_HOLD;
      n = 0;
      if (p == 1) begin
        queue_message(130, 1'b1);
        n = 130;
      end
      while (n < PHASE_BYTES) begin
        len = pick_len();
        queue_message(len, 1'b1);
        n += len;
      end
      // sometimes leave a message open so the next register update lands mid-message
      if ($urandom_range(1)) queue_message($urandom_range(90, 1), 1'b0);
      wait_drained();
    end

    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && expected_bytes.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
